>>> rtl/iir_direct_form_one_filter_defines.svh
// Assertion helpers used by the checker module.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define IIRDF1_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define IIRDF1_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/iirdf1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;
    localparam int FRAC_W    = 20;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 48;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_NUM0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEN1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAIN = 3'd7;

    localparam logic signed [COEF_W-1:0]   COEF_ONE   = 24'sd1048576;
    localparam logic signed [PROD_W-1:0]   ROUND_HALF = 48'sh0080_0000_0000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB,
        ACC_ROUND_LOW
    } t_acc_op;

    typedef struct packed {
        t_acc_op                   op;
        logic signed [COEF_W-1:0]  coeff;
        logic signed [COEF_W-1:0]  data;
    } t_mac_req;

endpackage

`default_nettype wire

>>> rtl/iirdf1_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface iirdf1_in_if
    import iirdf1_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       clear_history;

    modport source (output valid, output sample_in, output clear_history, input ready);
    modport sink   (input valid, input sample_in, input clear_history, output ready);
endinterface

`default_nettype wire

>>> rtl/iirdf1_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface iirdf1_out_if
    import iirdf1_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

>>> rtl/iir_direct_form_one_filter.sv
// One item is in flight at a time: a new item is accepted only once the previous result
// has gone into the output register. The single shared 24x24 multiplier runs 2*ORDER+1
// filter taps and two gain partial products per item.
// A waiting result is held in an output register while the next item is accepted.
// Reset (synchronous, active low) clears both histories, the control state and the result
// valid, and loads the coefficients with unity numerator tap zero and unity gain.
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_one_filter
    import iirdf1_pkg::*;
#(
    parameter int ORDER = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    iirdf1_in_if.sink                  i_sample_ch,
    iirdf1_out_if.source               o_result_ch,
    input  wire logic                  i_cfg_we,
    input  wire logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [COEF_W-1:0]     i_cfg_data
);

    localparam int NSTEP  = 2 * ORDER + 1;
    localparam int STEP_W = $clog2(NSTEP);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEP - 1);
    localparam logic [STEP_W-1:0] STEP_NUM_LAST = STEP_W'(ORDER);
    localparam logic [STEP_W-1:0] STEP_DEN_ACC = STEP_W'(ORDER + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_LOW,
        ST_HIGH,
        ST_FINAL,
        ST_OUT
    } t_state;

    t_state                      r_state;
    logic [STEP_W-1:0]           r_step;
    logic signed [SAMPLE_W-1:0]  r_x0;
    logic signed [SAMPLE_W-1:0]  r_xhist [ORDER];
    logic signed [SAMPLE_W-1:0]  r_yhist [ORDER];
    logic signed [COEF_W-1:0]    r_coef  [NUM_REGS];
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_sample;
    logic                        r_out_clip;

    logic                        w_in_acc;
    logic                        w_slot_free;
    logic [3:0]                  w_den_idx;
    logic [REG_IDX_W-1:0]        w_coef_idx;
    logic signed [SAMPLE_W-1:0]  w_tap;
    t_mac_req                    w_req;
    logic signed [ACC_W-1:0]     w_acc;
    logic                        w_fits;
    logic signed [SAMPLE_W-1:0]  w_sat;

    assign i_sample_ch.ready = (r_state == ST_IDLE);
    assign w_in_acc    = i_sample_ch.valid && i_sample_ch.ready;
    assign w_slot_free = !r_out_valid || o_result_ch.ready;

    // Steps 0..ORDER are numerator taps, the rest denominator taps.
    assign w_den_idx  = 4'(r_step) + 4'(REG_DEN1) - 4'd1 - 4'(ORDER);
    assign w_coef_idx = (r_step <= STEP_NUM_LAST) ? REG_IDX_W'(r_step)
                                                   : w_den_idx[REG_IDX_W-1:0];

    always_comb begin
        w_tap = r_x0;
        for (int k = 1; k <= ORDER; k++) begin
            if (r_step == STEP_W'(k)) begin
                w_tap = r_xhist[k-1];
            end
            if (r_step == STEP_W'(ORDER + k)) begin
                w_tap = r_yhist[k-1];
            end
        end
    end

    // Operands and accumulator action. The accumulator acts on the product
    // issued in the previous cycle.
    always_comb begin
        w_req.op    = ACC_HOLD;
        w_req.coeff = r_coef[REG_GAIN];
        w_req.data  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_req.op = ACC_CLEAR;
                end
            end
            ST_MAC: begin
                w_req.coeff = r_coef[w_coef_idx];
                w_req.data  = COEF_W'(w_tap);
                if (r_step == '0) begin
                    w_req.op = ACC_HOLD;
                end else if (r_step > STEP_DEN_ACC) begin
                    w_req.op = ACC_SUB;
                end else begin
                    w_req.op = ACC_ADD;
                end
            end
            ST_DRAIN: w_req.op = ACC_SUB;
            ST_LOW: begin
                w_req.data = {{(COEF_W - FRAC_W){1'b0}}, w_acc[FRAC_W-1:0]};
            end
            ST_HIGH: begin
                w_req.data = w_acc[FRAC_W+COEF_W-1:FRAC_W];
                w_req.op   = ACC_ROUND_LOW;
            end
            ST_FINAL: w_req.op = ACC_ADD;
            ST_OUT:   w_req.op = ACC_HOLD;
            default:  w_req.op = ACC_HOLD;
        endcase
    end

    iirdf1_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_acc (w_acc)
    );

    // The rounded result sits in bits above the fraction; it fits 16 bits
    // when every bit from the sign down to bit 15 of the result agrees.
    assign w_fits = (&w_acc[ACC_W-1:FRAC_W+SAMPLE_W-1])
                 || !(|w_acc[ACC_W-1:FRAC_W+SAMPLE_W-1]);
    assign w_sat  = w_fits ? w_acc[FRAC_W+SAMPLE_W-1:FRAC_W]
                           : (w_acc[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ORDER; k++) begin
                r_xhist[k] <= '0;
                r_yhist[k] <= '0;
            end
        end else begin
            if (r_out_valid && o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_x0    <= i_sample_ch.sample_in;
                        r_step  <= '0;
                        r_state <= ST_MAC;
                        if (i_sample_ch.clear_history) begin
                            for (int k = 0; k < ORDER; k++) begin
                                r_xhist[k] <= '0;
                                r_yhist[k] <= '0;
                            end
                        end
                    end
                end
                ST_MAC: begin
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_DRAIN: r_state <= ST_LOW;
                ST_LOW:   r_state <= ST_HIGH;
                ST_HIGH:  r_state <= ST_FINAL;
                ST_FINAL: r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= w_sat;
                        r_out_clip   <= !w_fits;
                        for (int k = 1; k < ORDER; k++) begin
                            r_xhist[k] <= r_xhist[k-1];
                            r_yhist[k] <= r_yhist[k-1];
                        end
                        r_xhist[0] <= r_x0;
                        r_yhist[0] <= w_sat;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[REG_NUM0] <= COEF_ONE;
            r_coef[REG_GAIN] <= COEF_ONE;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign o_result_ch.valid      = r_out_valid;
    assign o_result_ch.sample_out = r_out_sample;
    assign o_result_ch.clipped    = r_out_clip;

endmodule

`default_nettype wire

>>> rtl/iirdf1_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_mac
    import iirdf1_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_mac_req                i_req,
    output logic signed [ACC_W-1:0]      o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] w_qsum;
    logic signed [ACC_W-1:0]  w_low;

    // Low partial product plus one half, scaled down by 2^20 with floor.
    assign w_qsum = r_prod + ROUND_HALF;
    assign w_low  = {{FRAC_W{w_qsum[PROD_W-1]}}, w_qsum[PROD_W-1:FRAC_W]};

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.coeff) * PROD_W'(i_req.data);
        unique case (i_req.op)
            ACC_HOLD:      r_acc <= r_acc;
            ACC_CLEAR:     r_acc <= '0;
            ACC_ADD:       r_acc <= r_acc + r_prod;
            ACC_SUB:       r_acc <= r_acc - r_prod;
            ACC_ROUND_LOW: r_acc <= w_low;
            default:       r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

>>> rtl/iirdf1_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "iir_direct_form_one_filter_defines.svh"

module iirdf1_checker
    import iirdf1_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic signed [SAMPLE_W-1:0] i_out_sample,
    input wire logic                       i_out_clip
);

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;

    `IIRDF1_ASSERT_ALWAYS(a_reset_no_result, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `IIRDF1_ASSERT(a_busy_after_accept, w_in_acc |=> !i_in_ready, "ready right after an item")
    `IIRDF1_ASSERT(a_result_from_busy, $rose(i_out_valid) |-> $past(!i_in_ready), "result while idle")
    `IIRDF1_ASSERT(a_valid_holds, w_out_stall |=> i_out_valid, "result valid dropped in stall")
    `IIRDF1_ASSERT(a_payload_holds, w_out_stall |=> $stable(i_out_sample) && $stable(i_out_clip), "result changed in stall")

endmodule

bind iir_direct_form_one_filter iirdf1_checker u_iirdf1_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample_ch.valid),
    .i_in_ready   (i_sample_ch.ready),
    .i_out_valid  (o_result_ch.valid),
    .i_out_ready  (o_result_ch.ready),
    .i_out_sample (o_result_ch.sample_out),
    .i_out_clip   (o_result_ch.clipped)
);

`default_nettype wire

>>> bench/tb_iir_direct_form_one_filter.sv
`timescale 1ns / 1ps

module tb_iir_direct_form_one_filter;
    import iirdf1_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 105;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clear;
    } sample_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } filtered_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    iirdf1_in_if  sample_ch();
    iirdf1_out_if result_ch();

    iir_direct_form_one_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Local copy of the coefficient registers and the filter histories.
    logic signed [COEF_W-1:0]   coef_model [NUM_REGS];
    logic signed [COEF_W-1:0]   next_coef  [NUM_REGS];
    logic signed [SAMPLE_W-1:0] x_history  [3];
    logic signed [SAMPLE_W-1:0] y_history  [3];

    sample_item_t pending_samples[$];
    filtered_t    expected_outputs[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int clipped_count  = 0;
    int clear_count    = 0;
    int settings_count = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    logic sample_taken = 1'b0;

    function automatic filtered_t filter_sample(input sample_item_t item);
        longint acc;
        longint acc_hi;
        longint acc_lo;
        longint prod_hi;
        longint prod_lo;
        longint rounded;
        longint gain;
        filtered_t res;
        if (item.clear) begin
            for (int k = 0; k < 3; k++) begin
                x_history[k] = '0;
                y_history[k] = '0;
            end
        end
        acc = longint'(coef_model[REG_NUM0]) * longint'(item.sample);
        for (int k = 1; k <= 3; k++) begin
            acc += longint'(coef_model[REG_NUM0 + k]) * longint'(x_history[k-1]);
            acc -= longint'(coef_model[REG_DEN1 + k - 1]) * longint'(y_history[k-1]);
        end
        // Split the sum so the gain product stays exact, then round half up.
        gain    = longint'(coef_model[REG_GAIN]);
        acc_hi  = acc >>> FRAC_W;
        acc_lo  = acc - (acc_hi <<< FRAC_W);
        prod_hi = acc_hi * gain;
        prod_lo = acc_lo * gain + (longint'(1) <<< (2 * FRAC_W - 1));
        rounded = (prod_hi + (prod_lo >>> FRAC_W)) >>> FRAC_W;
        res.clipped = 1'b0;
        if (rounded > longint'(SAMPLE_MAX)) begin
            rounded = longint'(SAMPLE_MAX);
            res.clipped = 1'b1;
        end
        if (rounded < longint'(SAMPLE_MIN)) begin
            rounded = longint'(SAMPLE_MIN);
            res.clipped = 1'b1;
        end
        res.sample = rounded[SAMPLE_W-1:0];
        for (int k = 2; k > 0; k--) begin
            x_history[k] = x_history[k-1];
            y_history[k] = y_history[k-1];
        end
        x_history[0] = item.sample;
        y_history[0] = res.sample;
        return res;
    endfunction

    // Sample and ready driver: a new item is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (!sample_ch.valid || sample_taken) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    sample_ch.valid         <= 1'b1;
                    sample_ch.sample_in     <= pending_samples[0].sample;
                    sample_ch.clear_history <= pending_samples[0].clear;
                    void'(pending_samples.pop_front());
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts on every accepted sample and checks every accepted result.
    always @(posedge i_clk) begin
        filtered_t predicted;
        filtered_t wanted;
        sample_item_t item;
        if (!i_rst_n) begin
            sample_taken <= 1'b0;
        end else begin
            sample_taken <= sample_ch.valid && sample_ch.ready;
            if (sample_ch.valid && sample_ch.ready) begin
                item.sample = sample_ch.sample_in;
                item.clear  = sample_ch.clear_history;
                predicted   = filter_sample(item);
                expected_outputs.push_back(predicted);
                accepted_count <= accepted_count + 1;
                if (predicted.clipped) clipped_count <= clipped_count + 1;
                if (item.clear) clear_count <= clear_count + 1;
            end
            if (result_ch.valid && result_ch.ready) begin
                checked_count <= checked_count + 1;
                if (expected_outputs.size() == 0) begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("unexpected result: sample_out=%0d clipped=%0b",
                                 result_ch.sample_out, result_ch.clipped);
                end else begin
                    wanted = expected_outputs.pop_front();
                    if (result_ch.sample_out !== wanted.sample ||
                        result_ch.clipped !== wanted.clipped) begin
                        error_count <= error_count + 1;
                        if (error_count < 10)
                            $display("mismatch at result %0d: expected %0d/%0b, got %0d/%0b",
                                     checked_count, wanted.sample, wanted.clipped,
                                     result_ch.sample_out, result_ch.clipped);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[iir_direct_form_one_filter] ERROR");
            $finish;
        end
    end

    task automatic queue_item(input logic signed [SAMPLE_W-1:0] sample, input logic clear);
        sample_item_t item;
        item.sample = sample;
        item.clear  = clear;
        pending_samples.push_back(item);
        queued_count++;
    endtask

    // Holds the sender until every queued item has been answered.
    task automatic wait_idle();
        while (!(pending_samples.size() == 0 && accepted_count == queued_count &&
                 expected_outputs.size() == 0))
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_coefficients();
        for (int i = 0; i < NUM_REGS; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[REG_IDX_W-1:0];
            i_cfg_data <= next_coef[i];
            coef_model[i] = next_coef[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(9))
            0: s = SAMPLE_MAX;
            1: s = SAMPLE_MIN;
            2: s = SAMPLE_W'($signed($urandom_range(511)) - 256);
            3, 4: s = SAMPLE_W'($signed($urandom_range(8191)) - 4096);
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    // Style 0 spans the full range, style 1 keeps the filter tame, style 2 picks corners.
    function automatic logic signed [COEF_W-1:0] rand_coef(input int style);
        logic signed [COEF_W-1:0] c;
        case (style)
            0: c = COEF_W'($urandom);
            1: c = COEF_W'($signed($urandom_range(1 << 19)) - (1 << 18));
            default: begin
                case ($urandom_range(3))
                    0: c = 24'sh7fffff;
                    1: c = 24'sh800000;
                    2: c = '0;
                    default: c = COEF_ONE;
                endcase
            end
        endcase
        return c;
    endfunction

    initial begin
        int style;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_in = '0;
        sample_ch.clear_history = 1'b0;
        result_ch.ready = 1'b0;
        for (int i = 0; i < NUM_REGS; i++) coef_model[i] = '0;
        coef_model[REG_NUM0] = COEF_ONE;
        coef_model[REG_GAIN] = COEF_ONE;
        for (int k = 0; k < 3; k++) begin
            x_history[k] = '0;
            y_history[k] = '0;
        end
        send_idle_pct = 8;
        recv_idle_pct = 86;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Coefficients out of reset pass the input straight through.
        queue_item(SAMPLE_MAX, 1'b0);
        queue_item(SAMPLE_MIN, 1'b0);
        queue_item(16'sd0, 1'b0);
        queue_item(16'sd1, 1'b0);
        queue_item(-16'sd1, 1'b0);
        queue_item(16'sh5555, 1'b0);
        queue_item(16'shaaaa, 1'b1);
        queue_item(SAMPLE_MIN, 1'b1);
        wait_idle();

        // Largest taps and gain saturate high; a negative gain then reaches both limits.
        for (int i = 0; i < 4; i++) next_coef[REG_NUM0 + i] = 24'sh7fffff;
        for (int i = 0; i < 3; i++) next_coef[REG_DEN1 + i] = 24'sh800000;
        next_coef[REG_GAIN] = 24'sh7fffff;
        apply_coefficients();
        queue_item(SAMPLE_MAX, 1'b1);
        queue_item(SAMPLE_MIN, 1'b0);
        queue_item(SAMPLE_MAX, 1'b0);
        queue_item(16'sd0, 1'b1);
        queue_item(-16'sd1, 1'b0);
        wait_idle();

        next_coef[REG_GAIN] = 24'sh800000;
        apply_coefficients();
        queue_item(SAMPLE_MAX, 1'b1);
        queue_item(SAMPLE_MIN, 1'b1);
        queue_item(16'sd1, 1'b0);
        queue_item(SAMPLE_MIN, 1'b0);
        wait_idle();

        // A tap of one half puts results exactly on the rounding midpoint.
        for (int i = 0; i < NUM_REGS; i++) next_coef[i] = '0;
        next_coef[REG_NUM0] = 24'sh080000;
        next_coef[REG_GAIN] = COEF_ONE;
        apply_coefficients();
        queue_item(16'sd1, 1'b1);
        queue_item(-16'sd1, 1'b0);
        queue_item(16'sd3, 1'b0);
        queue_item(-16'sd3, 1'b0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 4) begin
                send_idle_pct = 8;
                recv_idle_pct = 86;
            end else if (p < 8) begin
                send_idle_pct = 86;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            style = (p % 4 == 3) ? 2 : ((p % 4 == 1) ? 0 : 1);
            for (int i = 0; i < NUM_REGS; i++) next_coef[i] = rand_coef(style);
            if (style == 1) begin
                next_coef[REG_NUM0] = COEF_W'($signed($urandom_range(1 << 21)) - (1 << 20));
                next_coef[REG_GAIN] = COEF_W'($urandom_range(1 << 21, 1 << 19));
                if ($urandom_range(3) == 0) next_coef[REG_GAIN] = -next_coef[REG_GAIN];
            end
            apply_coefficients();
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_item(rand_sample(), $urandom_range(19) == 0);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_outputs.size() != 0) begin
            $display("%0d expected results never arrived", expected_outputs.size());
            error_count++;
        end
        $display("Checked %0d filtered samples over %0d coefficient settings.",
                 checked_count, settings_count);
        $display("%0d results clipped, %0d history clears, %0d mismatches.",
                 clipped_count, clear_count, error_count);
        if (error_count == 0) begin
            $display("[iir_direct_form_one_filter] OK");
        end else begin
            $display("[iir_direct_form_one_filter] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/iirdf1_pkg.sv
rtl/iirdf1_in_if.sv
rtl/iirdf1_out_if.sv
rtl/iirdf1_mac.sv
rtl/iir_direct_form_one_filter.sv
rtl/iirdf1_checker.sv
bench/tb_iir_direct_form_one_filter.sv
